// File: sv/rrp_pkg.sv
// Package with the shared types and constants of the rotation rate profile block.
package rrp_pkg;

    // Selector codes carried in the input tuser.
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Largest rate magnitude in Q8.24.
    localparam logic [31:0] RATE_MAX = 32'h7FFF_FFFF;

    // Reset values of the configuration registers.
    localparam logic [31:0] STEP_GAIN_RST     = 32'd0;
    localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd4294967;
    localparam logic [15:0] RISE_LIMIT_RST    = 16'd4095;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_STEP_GAIN     = 2'd0;
    localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd1;
    localparam logic [1:0] REG_RISE_LIMIT    = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_RISE = 3'b010,
        PH_FALL = 3'b100
    } phase_t;

    typedef struct packed {
        logic [31:0] step_gain;
        logic [31:0] sample_period;
        logic [15:0] rise_limit;
    } cfg_t;

    typedef struct packed {
        logic [31:0] omega;
        logic        active;
        logic        last;
        logic        overrun;
    } result_t;

endpackage

// File: sv/rrp_cfg.sv
// Configuration register file of the rotation rate profile block, APB-style port.
module rrp_cfg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output rrp_pkg::cfg_t        cfg
);

    logic [31:0] step_gain_reg;
    logic [31:0] sample_period_reg;
    logic [15:0] rise_limit_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_gain_reg     <= rrp_pkg::STEP_GAIN_RST;
            sample_period_reg <= rrp_pkg::SAMPLE_PERIOD_RST;
            rise_limit_reg    <= rrp_pkg::RISE_LIMIT_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                rrp_pkg::REG_STEP_GAIN:     step_gain_reg     <= pwdata;
                rrp_pkg::REG_SAMPLE_PERIOD: sample_period_reg <= pwdata;
                rrp_pkg::REG_RISE_LIMIT:    rise_limit_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            rrp_pkg::REG_STEP_GAIN:     prdata = step_gain_reg;
            rrp_pkg::REG_SAMPLE_PERIOD: prdata = sample_period_reg;
            rrp_pkg::REG_RISE_LIMIT:    prdata = {16'd0, rise_limit_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    assign cfg.step_gain     = step_gain_reg;
    assign cfg.sample_period = sample_period_reg;
    assign cfg.rise_limit    = rise_limit_reg;

endmodule

// File: sv/rrp_core.sv
// Profile state and the per-item update logic of the rotation rate profile block.
module rrp_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_fire,
    input  logic               item_func,
    input  logic [31:0]        item_angle,
    input  logic [15:0]        item_friction,
    input  rrp_pkg::cfg_t      cfg,
    output logic               res_valid,
    output rrp_pkg::result_t   res
);

    rrp_pkg::phase_t phase_reg, phase_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] swept_reg, swept_next;
    logic [31:0] half_reg, half_next;
    logic [31:0] step_reg, step_next;
    logic        pos_reg, pos_next;
    logic [15:0] ticks_reg, ticks_next;

    // Start arithmetic.
    logic [31:0] ang_neg;
    logic [31:0] ang_abs;
    logic [47:0] step_prod;
    logic [31:0] step_start;

    // Rise arithmetic.
    logic [32:0] rate_sum;
    logic [31:0] rate_rise;
    logic [63:0] sweep_prod;
    logic [32:0] sweep_sum;
    logic [31:0] swept_rise;
    logic [15:0] ticks_inc;
    logic [15:0] lim;
    logic        reached;

    // Fall arithmetic.
    logic [15:0] ticks_dec;
    logic [47:0] fall_prod;
    logic [31:0] rate_fall;

    logic [31:0] mag;

    assign ang_neg    = 32'd0 - item_angle;
    assign ang_abs    = item_angle[31] ? ang_neg : item_angle;
    assign step_prod  = 48'(item_friction) * 48'(cfg.step_gain);
    // The Q2.14 friction scale drops 14 bits; anything above bit 30 saturates.
    assign step_start = (step_prod[47:45] != 3'd0) ? rrp_pkg::RATE_MAX
                                                    : {1'b0, step_prod[44:14]};

    assign rate_sum   = {1'b0, rate_reg} + {1'b0, step_reg};
    assign rate_rise  = (rate_sum > {1'b0, rrp_pkg::RATE_MAX}) ? rrp_pkg::RATE_MAX
                                                               : rate_sum[31:0];
    assign sweep_prod = 64'(rate_rise) * 64'(cfg.sample_period);
    assign sweep_sum  = {1'b0, swept_reg} + {1'b0, sweep_prod[63:32]};
    assign swept_rise = sweep_sum[32] ? 32'hFFFF_FFFF : sweep_sum[31:0];
    assign ticks_inc  = ticks_reg + 16'd1;
    assign lim        = (cfg.rise_limit == 16'd0) ? 16'd1 : cfg.rise_limit;
    assign reached    = swept_rise >= half_reg;

    assign ticks_dec  = (ticks_reg == 16'd0) ? 16'd0 : ticks_reg - 16'd1;
    assign fall_prod  = 48'(ticks_dec) * 48'(step_reg);
    assign rate_fall  = (fall_prod[47:31] != 17'd0) ? rrp_pkg::RATE_MAX
                                                    : fall_prod[31:0];

    always_comb
    begin
        phase_next = phase_reg;
        rate_next  = rate_reg;
        swept_next = swept_reg;
        half_next  = half_reg;
        step_next  = step_reg;
        pos_next   = pos_reg;
        ticks_next = ticks_reg;
        res_valid  = 1'b0;
        mag        = 32'd0;
        res        = '0;
        if (item_fire)
        begin
            if (item_func == rrp_pkg::FUNC_START)
            begin
                pos_next   = !item_angle[31] && (item_angle != 32'd0);
                half_next  = {1'b0, ang_abs[31:1]};
                step_next  = step_start;
                rate_next  = 32'd0;
                swept_next = 32'd0;
                ticks_next = 16'd0;
                phase_next = rrp_pkg::PH_RISE;
            end
            else
            begin
                res_valid = 1'b1;
                case (phase_reg)
                    rrp_pkg::PH_RISE:
                    begin
                        rate_next  = rate_rise;
                        swept_next = swept_rise;
                        ticks_next = ticks_inc;
                        mag        = rate_rise;
                        res.active = 1'b1;
                        if (reached || (ticks_inc >= lim))
                        begin
                            res.overrun = !reached;
                            phase_next  = rrp_pkg::PH_FALL;
                        end
                        res.omega = pos_reg ? mag : 32'd0 - mag;
                    end
                    rrp_pkg::PH_FALL:
                    begin
                        ticks_next = ticks_dec;
                        res.active = 1'b1;
                        if (ticks_dec == 16'd0)
                        begin
                            rate_next  = 32'd0;
                            phase_next = rrp_pkg::PH_IDLE;
                            res.last   = 1'b1;
                            res.omega  = 32'd0;
                        end
                        else
                        begin
                            rate_next = rate_fall;
                            mag       = rate_fall;
                            res.omega = pos_reg ? mag : 32'd0 - mag;
                        end
                    end
                    default:
                    begin
                        // A tick with no profile running gives an all-zero sample.
                        phase_next = rrp_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rrp_pkg::PH_IDLE;
            rate_reg  <= 32'd0;
            swept_reg <= 32'd0;
            half_reg  <= 32'd0;
            step_reg  <= 32'd0;
            pos_reg   <= 1'b0;
            ticks_reg <= 16'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            rate_reg  <= rate_next;
            swept_reg <= swept_next;
            half_reg  <= half_next;
            step_reg  <= step_next;
            pos_reg   <= pos_next;
            ticks_reg <= ticks_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_fall_has_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == rrp_pkg::PH_FALL) |-> (ticks_reg != 16'd0))
        else $error("fall phase with zero rise tick count");

    a_idle_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == rrp_pkg::PH_IDLE) |-> (rate_reg == 32'd0))
        else $error("idle phase with nonzero rate");

    a_step_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        !step_reg[31] && !rate_reg[31])
        else $error("rate step or rate magnitude above saturation limit");

    a_last_ends_profile: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.last) |=> (phase_reg == rrp_pkg::PH_IDLE))
        else $error("closing sample did not return the profile to idle");
`endif

endmodule

// File: sv/rrp_out_reg.sv
// Result register of the rotation rate profile block, driving the master stream side.
module rrp_out_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  rrp_pkg::result_t   res,
    output logic               can_load,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);

    logic             valid_reg, valid_next;
    rrp_pkg::result_t res_reg;

    assign can_load   = !valid_reg || m_tready;
    assign valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.omega;
    assign m_tuser  = {res_reg.overrun, res_reg.active};
    assign m_tlast  = res_reg.last;

endmodule

// File: sv/rotation_rate_profile.sv
// Top level of the rotation rate profile block: input register, profile core, result register.
// A tick's sample reaches m_tdata through the input register and then the result register.
// One item per cycle unless m_tready stalls; every tick gives one sample, a start none.
// A rise tick's work is one rate add, one 32x32 multiply and one swept-angle add and compare.
// Reset (rst_n low, asynchronous) empties both registers, sets the profile idle
// and loads the configuration registers with their reset values.
module rotation_rate_profile
(
    input  logic        clk,
    input  logic        rst_n,
    // APB-style configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] angle, [47:32] friction
    input  logic        s_tuser,   // [0] func
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] omega
    output logic [1:0]  m_tuser,   // [0] active, [1] overrun
    output logic        m_tlast    // closing zero sample of the profile
);

    rrp_pkg::cfg_t    cfg;
    rrp_pkg::result_t res;
    logic             res_valid;
    logic             can_load;

    // Input register holding one accepted item until the core consumes it.
    logic        in_valid_reg, in_valid_next;
    logic        in_func_reg;
    logic [31:0] in_angle_reg;
    logic [15:0] in_friction_reg;
    logic        consume;
    logic        in_take;

    // A start produces no sample, so it never waits on the result register.
    assign consume = in_valid_reg && ((in_func_reg == rrp_pkg::FUNC_START) || can_load);
    assign s_tready = !in_valid_reg || consume;
    assign in_take  = s_tvalid && s_tready;
    assign in_valid_next = in_take ? 1'b1 : (consume ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_func_reg     <= s_tuser;
            in_angle_reg    <= s_tdata[31:0];
            in_friction_reg <= s_tdata[47:32];
        end
    end

    rrp_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The core updates the profile state in the cycle the item is consumed,
    // so the next tick sees the new state right away.
    rrp_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_fire     (consume),
        .item_func     (in_func_reg),
        .item_angle    (in_angle_reg),
        .item_friction (in_friction_reg),
        .cfg           (cfg),
        .res_valid     (res_valid),
        .res           (res)
    );

    rrp_out_reg u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
